// ----- rtl/ialu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_pkg - shared definitions for the iterative integer ALU
// Command codes, field widths and the default datapath width.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int DATA_WIDTH_DEF = 64;
  localparam int CMD_W          = 3;

  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MOD = 3'd4;

endpackage : ialu_pkg
`default_nettype wire

// ----- rtl/iterative_integer_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iterative_integer_alu - unsigned add/sub/mul/div/mod over one shared adder
// Multiply is shift-and-add, divide and modulo are restoring division, one
// bit per cycle through the same (DATA_WIDTH+1)-bit add/subtract unit.
//
//  channel  | dir | beat contents (low bit first)
//  ---------+-----+---------------------------------------------------
//  s_axis   | in  | cmd[2:0], operand_a, operand_b, zero pad to bytes
//  m_axis   | out | result, zero pad to bytes
//
// Sequence: add/sub and unused commands accept, make one adder pass, then show
// the result; mul/div/mod take one bit per adder pass before the result.
// s_axis_tready is high only while idle; one beat is in flight at a time.
// The result holds in its register until m_axis takes it; a stalled
// m_axis_tready stalls the input side.
// Reset (rst, synchronous) returns the sequencer to idle and drops tvalid.
// ----------------------------------------------------------------------------
module iterative_integer_alu
  import ialu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // cmd, operand_a, operand_b, zero pad
  input  wire logic [((CMD_W + 2*DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // result, zero pad
  output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int DW     = DATA_WIDTH;
  localparam int OUT_W  = ((DW + 7) / 8) * 8;
  localparam int CNT_W  = $clog2(DW);
  localparam int XW     = DW + 1;
  localparam int SW     = DW + 2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [CMD_W-1:0] cmd_q;
  logic [DW-1:0]    opa;
  logic [DW-1:0]    opb;
  logic [DW-1:0]    acc;
  logic [DW-1:0]    res;
  logic [CNT_W-1:0] cnt;

  logic             in_beat;
  logic             out_beat;
  logic             last_step;
  logic             step_done;

  // shared adder
  logic [XW-1:0]    add_x;
  logic [XW-1:0]    add_y;
  logic             add_sub;
  logic [SW-1:0]    add_sum;
  logic             add_ge;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_beat  = m_axis_tvalid && m_axis_tready;
  assign last_step = (cnt == CNT_W'(DW - 1));

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_DONE);
  assign m_axis_tdata  = OUT_W'(res);

  always_comb begin
    add_x   = '0;
    add_y   = {1'b0, opb};
    add_sub = 1'b0;
    case (cmd_q)
      CMD_ADD: begin
        add_x = {1'b0, opa};
      end
      CMD_SUB: begin
        add_x   = {1'b0, opa};
        add_sub = 1'b1;
      end
      CMD_MUL: begin
        add_x = {1'b0, acc};
      end
      CMD_DIV, CMD_MOD: begin
        // partial remainder shifted left with the next dividend bit
        add_x   = {acc, opa[DW-1]};
        add_sub = 1'b1;
      end
      default: begin
        add_x = '0;
        add_y = '0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + SW'(add_sub);
  assign add_ge  = add_sum[SW-1];  // no borrow: x >= y

  // multi-bit commands finish on the last step, the rest after one pass
  always_comb begin
    case (cmd_q)
      CMD_MUL, CMD_DIV, CMD_MOD: step_done = last_step;
      default:                   step_done = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_beat) state_next = ST_RUN;
      ST_RUN:  if (step_done) state_next = ST_DONE;
      ST_DONE: if (out_beat) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (in_beat) begin
        cnt <= '0;
      end else if (state == ST_RUN) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_q <= s_axis_tdata[CMD_W-1:0];
      opa   <= s_axis_tdata[CMD_W +: DW];
      opb   <= s_axis_tdata[CMD_W + DW +: DW];
      acc   <= '0;
    end else if (state == ST_RUN) begin
      case (cmd_q)
        CMD_ADD, CMD_SUB: begin
          res <= add_sum[DW-1:0];
        end
        CMD_MUL: begin
          if (opa[0]) acc <= add_sum[DW-1:0];
          opa <= opa >> 1;
          opb <= opb << 1;
          if (last_step) res <= opa[0] ? add_sum[DW-1:0] : acc;
        end
        CMD_DIV, CMD_MOD: begin
          // remainder in acc, quotient shifts into opa as the dividend leaves
          acc <= add_ge ? add_sum[DW-1:0] : add_x[DW-1:0];
          opa <= {opa[DW-2:0], add_ge};
          if (last_step) begin
            if (cmd_q == CMD_DIV) res <= {opa[DW-2:0], add_ge};
            else                  res <= add_ge ? add_sum[DW-1:0] : add_x[DW-1:0];
          end
        end
        default: begin
          res <= '0;
        end
      endcase
    end
  end

endmodule : iterative_integer_alu
`default_nettype wire

// ----- rtl/ialu_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_checker - port-level checks for the iterative integer ALU
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ialu_checker
  import ialu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic [((CMD_W + 2*DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int DW = DATA_WIDTH;

  // one beat in flight: never ready for input while a result is shown
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // a result never appears the cycle right after an input beat
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("result too early after input beat");

  // an add beat gives its sum once the sequencer has passed through the run state
  a_add_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tdata[CMD_W-1:0] == CMD_ADD))
    |=> ##1 (m_axis_tvalid && (m_axis_tdata[DW-1:0] ==
             $past(s_axis_tdata[CMD_W +: DW] + s_axis_tdata[CMD_W + DW +: DW], 2))))
    else $error("add result wrong or late");

  // a taken result is not shown again
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
    else $error("result repeated");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule : ialu_checker

bind iterative_integer_alu ialu_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_ialu_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire

// ----- sim/ialu_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ialu_result_checker - result checker for the iterative integer ALU
// Watches both stream channels, computes the expected result of every
// accepted input beat and compares each output beat, in order, against it.
// ----------------------------------------------------------------------------
module ialu_result_checker
  import ialu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  // cmd, operand_a, operand_b, zero pad
  input  logic [((CMD_W + 2*DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  // result, zero pad
  input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output int   mismatches,
  output int   outstanding
);

  localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0] result;
  } alu_op_t;

  alu_op_t results_due[$];

  // One quotient bit per step; partial remainder carries one extra bit so the
  // unsigned compare holds for divisors with the top bit set.
  function automatic void divide_restoring(
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder
  );
    logic [DATA_WIDTH:0]   partial;
    logic [DATA_WIDTH-1:0] quot;
    partial = '0;
    quot    = '0;
    for (int i = DATA_WIDTH - 1; i >= 0; i--) begin
      partial = {partial[DATA_WIDTH-1:0], dividend[i]};
      quot    = quot << 1;
      if (partial >= {1'b0, divisor}) begin
        partial = partial - {1'b0, divisor};
        quot[0] = 1'b1;
      end
    end
    quotient  = quot;
    remainder = partial[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [DATA_WIDTH-1:0] alu_compute(
    input logic [CMD_W-1:0]      cmd,
    input logic [DATA_WIDTH-1:0] a,
    input logic [DATA_WIDTH-1:0] b
  );
    logic [DATA_WIDTH-1:0] quot;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] res;
    divide_restoring(a, b, quot, rem);
    case (cmd)
      CMD_ADD: res = a + b;
      CMD_SUB: res = a - b;
      CMD_MUL: res = a * b;
      CMD_DIV: res = quot;
      CMD_MOD: res = (b == '0) ? a : rem;
      default: res = '0;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    alu_op_t          op;
    logic [OUT_W-1:0] want;
    int               errs;
    errs = 0;
    if (rst) begin
      results_due.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        op.cmd    = s_axis_tdata[CMD_W-1:0];
        op.a      = s_axis_tdata[CMD_W +: DATA_WIDTH];
        op.b      = s_axis_tdata[CMD_W + DATA_WIDTH +: DATA_WIDTH];
        op.result = alu_compute(op.cmd, op.a, op.b);
        results_due.push_back(op);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: result beat with none due: expected nothing, got %h",
                   $time, m_axis_tdata);
          errs++;
        end else begin
          op   = results_due.pop_front();
          want = op.result;
          if (m_axis_tdata !== want) begin
            $display("%0t ns: cmd %0d a %h b %h: expected %h, got %h",
                     $time, op.cmd, op.a, op.b, want, m_axis_tdata);
            errs++;
          end
        end
      end
      outstanding <= results_due.size();
      mismatches  <= mismatches + errs;
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for iterative_integer_alu
// Directed corner operations, then random commands and operands, with random
// gaps on the input stream and random back-pressure on the result stream.
// ----------------------------------------------------------------------------
module tb;
  import ialu_pkg::*;

  localparam int DW          = DATA_WIDTH_DEF;
  localparam int IN_W        = ((CMD_W + 2*DW + 7) / 8) * 8;
  localparam int OUT_W       = ((DW + 7) / 8) * 8;
  localparam int N_RANDOM    = 1300;
  localparam int QUIET_TAIL  = 150;
  localparam int DRAIN_WAIT  = 80;
  localparam int CYCLE_LIMIT = 1000000;

  // codes the block does not decode; each still returns a zero result
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  localparam logic [DW-1:0] ONES = '1;
  localparam logic [DW-1:0] MSB  = {1'b1, {(DW-1){1'b0}}};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  int mismatches;
  int outstanding;
  int cycles = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  always #2 clk = ~clk;

  iterative_integer_alu uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ialu_result_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result-side back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left    <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [DW-1:0] rand_word();
    logic [DW-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = ONES;
      2: w = DW'($urandom_range(0, 255));
      3: w = DW'(1) << $urandom_range(0, DW - 1);
      4: w = w | MSB;
      5, 6: w = w >> $urandom_range(0, DW - 1);
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [CMD_W-1:0] rand_cmd();
    logic [CMD_W-1:0] c;
    case ($urandom_range(0, 20))
      0, 1, 2, 3:     c = CMD_ADD;
      4, 5, 6, 7:     c = CMD_SUB;
      8, 9, 10, 11:   c = CMD_MUL;
      12, 13, 14, 15: c = CMD_DIV;
      16, 17, 18:     c = CMD_MOD;
      19:             c = CMD_RSVD5;
      default:        c = ($urandom_range(0, 1) != 0) ? CMD_RSVD6 : CMD_RSVD7;
    endcase
    return c;
  endfunction

  // starts at a falling edge, returns at the rising edge that takes the beat
  task automatic send_op(input logic [CMD_W-1:0] cmd, input logic [DW-1:0] a,
                         input logic [DW-1:0] b);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - CMD_W - 2*DW){1'b0}}, b, a, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  initial begin
    logic [CMD_W-1:0] c;
    logic [DW-1:0]    a;
    logic [DW-1:0]    b;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corners: wrap, borrow, overflowing product, zero and large divisors
    send_op(CMD_ADD, ONES, DW'(1));
    send_op(CMD_ADD, ONES, ONES);
    send_op(CMD_ADD, '0, '0);
    send_op(CMD_SUB, '0, DW'(1));
    send_op(CMD_SUB, '0, ONES);
    send_op(CMD_SUB, ONES, ONES);
    send_op(CMD_MUL, ONES, ONES);
    send_op(CMD_MUL, MSB, DW'(2));
    send_op(CMD_MUL, '0, ONES);
    send_op(CMD_MUL, {$urandom, $urandom}, {$urandom, $urandom});
    send_op(CMD_DIV, ONES, '0);
    send_op(CMD_DIV, '0, '0);
    send_op(CMD_DIV, ONES, DW'(1));
    send_op(CMD_DIV, ONES, ONES);
    send_op(CMD_DIV, ONES, MSB);
    send_op(CMD_DIV, ONES, MSB | DW'(1));
    send_op(CMD_DIV, DW'(7), ONES);
    send_op(CMD_MOD, {$urandom, $urandom}, '0);
    send_op(CMD_MOD, ONES, MSB);
    send_op(CMD_MOD, ONES - DW'(1), ONES);
    send_op(CMD_MOD, ONES, ONES - DW'(1));
    send_op(CMD_MOD, DW'(1000), DW'(7));
    send_op(CMD_RSVD5, ONES, ONES);
    send_op(CMD_RSVD6, {$urandom, $urandom}, {$urandom, $urandom});
    send_op(CMD_RSVD7, ONES, DW'(1));

    for (int i = 0; i < N_RANDOM; i++) begin
      // idle windows come and go; none in the tail
      idle_on = ((i / 100) % 3 != 2) && (i < N_RANDOM - QUIET_TAIL);
      c = rand_cmd();
      a = rand_word();
      b = rand_word();
      send_op(c, a, b);
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    idle_on = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
